// File: hw/rtl/v3a_pkg.sv
`timescale 1ns / 1ps
// Package for the vector ALU: operation codes and item types.
package v3a_pkg;

    typedef enum logic [2:0] {
        OP_DOT    = 3'd0,
        OP_CROSS  = 3'd1,
        OP_LENGTH = 3'd2,
        OP_NORM   = 3'd3,
        OP_NEG    = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] scalar_out;
        logic               overflow;
    } t_out_item;

endpackage

// File: hw/rtl/v3a_sqrt_cell.sv
`timescale 1ns / 1ps
// One digit cell of the square root chain: settles one root bit per item.
module v3a_sqrt_cell import v3a_pkg::*; #(
    parameter int SW = 64,
    parameter int K  = 0,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [SW-1:0] i_x,
    input  logic [SW-1:0] i_res,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    output logic [SW-1:0] o_x,
    output logic [SW-1:0] o_res,
    output logic [DW-1:0] o_data
);

    localparam logic [SW:0] BIT = {{SW{1'b0}}, 1'b1} << (2 * K);

    logic          r_valid;
    logic [SW-1:0] r_x;
    logic [SW-1:0] r_res;
    logic [DW-1:0] r_data;
    logic [SW-1:0] n_x;
    logic [SW-1:0] n_res;
    logic [SW:0]   s_trial;
    logic          s_take;

    always_comb begin
        s_trial = {1'b0, i_res} + BIT;
        s_take  = ({1'b0, i_x} >= s_trial);
        if (s_take) begin
            n_x   = i_x - s_trial[SW-1:0];
            n_res = (i_res >> 1) + BIT[SW-1:0];
        end else begin
            n_x   = i_x;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_res  <= n_res;
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_res   = r_res;
    assign o_data  = r_data;

endmodule

// File: hw/rtl/v3a_div_cell.sv
`timescale 1ns / 1ps
// One digit cell of the divider chain: one quotient bit for each of three lanes.
module v3a_div_cell import v3a_pkg::*; #(
    parameter int NW = 49,
    parameter int LW = 33,
    parameter int QW = 17,
    parameter int J  = 0,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_rem [3],
    input  logic [QW-1:0] i_q [3],
    input  logic [LW-1:0] i_div,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    output logic [NW-1:0] o_rem [3],
    output logic [QW-1:0] o_q [3],
    output logic [LW-1:0] o_div,
    output logic [DW-1:0] o_data
);

    localparam logic [QW-1:0] QBIT = {{(QW-1){1'b0}}, 1'b1} << J;

    logic          r_valid;
    logic [NW-1:0] r_rem [3];
    logic [QW-1:0] r_q [3];
    logic [LW-1:0] r_div;
    logic [DW-1:0] r_data;
    logic [NW-1:0] n_rem [3];
    logic [QW-1:0] n_q [3];
    logic [NW-1:0] s_d;

    always_comb begin
        s_d = NW'(i_div) << J;
        for (int i = 0; i < 3; i++) begin
            if (i_rem[i] >= s_d) begin
                n_rem[i] = i_rem[i] - s_d;
                n_q[i]   = i_q[i] | QBIT;
            end else begin
                n_rem[i] = i_rem[i];
                n_q[i]   = i_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_q    <= n_q;
            r_div  <= i_div;
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_q     = r_q;
    assign o_div   = r_div;
    assign o_data  = r_data;

endmodule

// File: hw/rtl/vector3_alu.sv
`timescale 1ns / 1ps
// Vector ALU top level: products, rounding, root chain, divider chain, output register.
// Takes one item per cycle while no result waits at the output, and returns one result
// per item, in order. The path is a products stage, a sums stage, one cell per root bit
// in the square root chain (RB is WORD_BITS clamped to 2..32), one finishing stage, one
// cell per quotient bit in the divider chain (the three normalize lanes run side by
// side), and the output register. Every op takes the same path, so ordering is kept;
// the whole pipe holds while a result waits.
module vector3_alu import v3a_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int RB   = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 2) ? 2 : WORD_BITS);
    localparam int SW   = 2 * RB;
    localparam int SUMW = SW + 2;
    localparam int LW   = RB + 1;
    localparam int QW   = FRAC_BITS + 1;
    localparam int NW   = RB + FRAC_BITS + 1;

    localparam logic signed [SUMW-1:0] SAT_HI =
        $signed({{(SUMW-RB+1){1'b0}}, {(RB-1){1'b1}}});
    localparam logic signed [SUMW-1:0] SAT_LO =
        $signed({{(SUMW-RB+1){1'b1}}, {(RB-1){1'b0}}});
    localparam logic [SUMW-1:0] HALF_W = {{(SUMW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [31:0] OUT_HI = 32'(SAT_HI);
    localparam logic signed [31:0] OUT_LO = 32'(SAT_LO);

    typedef struct packed {
        logic [2:0]         op;
        logic signed [RB-1:0] rx;
        logic signed [RB-1:0] ry;
        logic signed [RB-1:0] rz;
        logic signed [RB-1:0] sc;
        logic               ov;
    } t_bundle;

    localparam int BW = $bits(t_bundle);

    // saturate to RB bits; top bit of the return is the overflow flag
    function automatic logic [RB:0] sat_w(input logic signed [SUMW-1:0] v);
        logic [RB:0] res;
        if (v > SAT_HI) begin
            res = {1'b1, SAT_HI[RB-1:0]};
        end else if (v < SAT_LO) begin
            res = {1'b1, SAT_LO[RB-1:0]};
        end else begin
            res = {1'b0, v[RB-1:0]};
        end
        return res;
    endfunction

    logic s_en;
    assign s_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = s_en;

    // ---------------- stage 1: products ----------------
    logic signed [RB-1:0] s_ax, s_ay, s_az, s_bx, s_by, s_bz;
    logic signed [RB-1:0] s_u [6];
    logic signed [RB-1:0] s_v [6];
    logic signed [SW-1:0] n_m [6];
    logic signed [SW-1:0] r_m [6];
    logic                 r_v1;
    logic [2:0]           r_op1;
    logic signed [RB-1:0] r_a1x, r_a1y, r_a1z;

    assign s_ax = $signed(i_in_item.ax[RB-1:0]);
    assign s_ay = $signed(i_in_item.ay[RB-1:0]);
    assign s_az = $signed(i_in_item.az[RB-1:0]);
    assign s_bx = $signed(i_in_item.bx[RB-1:0]);
    assign s_by = $signed(i_in_item.by[RB-1:0]);
    assign s_bz = $signed(i_in_item.bz[RB-1:0]);

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            s_u[i] = '0;
            s_v[i] = '0;
        end
        case (i_in_item.op)
            OP_DOT: begin
                s_u[0] = s_ax; s_v[0] = s_bx;
                s_u[1] = s_ay; s_v[1] = s_by;
                s_u[2] = s_az; s_v[2] = s_bz;
            end
            OP_CROSS: begin
                s_u[0] = s_ay; s_v[0] = s_bz;
                s_u[1] = s_az; s_v[1] = s_by;
                s_u[2] = s_az; s_v[2] = s_bx;
                s_u[3] = s_ax; s_v[3] = s_bz;
                s_u[4] = s_ax; s_v[4] = s_by;
                s_u[5] = s_ay; s_v[5] = s_bx;
            end
            OP_LENGTH, OP_NORM: begin
                s_u[0] = s_ax; s_v[0] = s_ax;
                s_u[1] = s_ay; s_v[1] = s_ay;
                s_u[2] = s_az; s_v[2] = s_az;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 6; i++) begin
            n_m[i] = s_u[i] * s_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_en) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_m   <= n_m;
            r_op1 <= i_in_item.op;
            r_a1x <= s_ax;
            r_a1y <= s_ay;
            r_a1z <= s_az;
        end
    end

    // ---------------- stage 2: sums, rounding, saturation ----------------
    logic signed [SUMW-1:0] s_dot, s_cx, s_cy, s_cz;
    logic [RB:0]            s_dot_s, s_cx_s, s_cy_s, s_cz_s, s_nx_s, s_ny_s, s_nz_s;
    logic [SW-1:0]          n_sq;
    t_bundle                n_b2;
    t_bundle                r_b2;
    logic [SW-1:0]          r_x2;
    logic                   r_v2;

    always_comb begin
        s_dot = (SUMW'(r_m[0]) + SUMW'(r_m[1]) + SUMW'(r_m[2]) + $signed(HALF_W))
                >>> FRAC_BITS;
        s_cx  = (SUMW'(r_m[0]) - SUMW'(r_m[1]) + $signed(HALF_W)) >>> FRAC_BITS;
        s_cy  = (SUMW'(r_m[2]) - SUMW'(r_m[3]) + $signed(HALF_W)) >>> FRAC_BITS;
        s_cz  = (SUMW'(r_m[4]) - SUMW'(r_m[5]) + $signed(HALF_W)) >>> FRAC_BITS;
        s_dot_s = sat_w(s_dot);
        s_cx_s  = sat_w(s_cx);
        s_cy_s  = sat_w(s_cy);
        s_cz_s  = sat_w(s_cz);
        s_nx_s  = sat_w(-SUMW'(r_a1x));
        s_ny_s  = sat_w(-SUMW'(r_a1y));
        s_nz_s  = sat_w(-SUMW'(r_a1z));
        n_sq    = $unsigned(r_m[0]) + $unsigned(r_m[1]) + $unsigned(r_m[2]);

        n_b2    = '0;
        n_b2.op = r_op1;
        case (r_op1)
            OP_DOT: begin
                n_b2.sc = $signed(s_dot_s[RB-1:0]);
                n_b2.ov = s_dot_s[RB];
            end
            OP_CROSS: begin
                n_b2.rx = $signed(s_cx_s[RB-1:0]);
                n_b2.ry = $signed(s_cy_s[RB-1:0]);
                n_b2.rz = $signed(s_cz_s[RB-1:0]);
                n_b2.ov = s_cx_s[RB] | s_cy_s[RB] | s_cz_s[RB];
            end
            OP_LENGTH, OP_NORM: begin
                // carry vector a along for the divider
                n_b2.rx = r_a1x;
                n_b2.ry = r_a1y;
                n_b2.rz = r_a1z;
            end
            OP_NEG: begin
                n_b2.rx = $signed(s_nx_s[RB-1:0]);
                n_b2.ry = $signed(s_ny_s[RB-1:0]);
                n_b2.rz = $signed(s_nz_s[RB-1:0]);
                n_b2.ov = s_nx_s[RB] | s_ny_s[RB] | s_nz_s[RB];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_b2 <= n_b2;
            r_x2 <= n_sq;
        end
    end

    // ---------------- square root chain ----------------
    logic          w_sv [RB+1];
    logic [SW-1:0] w_sx [RB+1];
    logic [SW-1:0] w_sr [RB+1];
    logic [BW-1:0] w_sb [RB+1];

    assign w_sv[0] = r_v2;
    assign w_sx[0] = r_x2;
    assign w_sr[0] = '0;
    assign w_sb[0] = r_b2;

    for (genvar g = 0; g < RB; g++) begin : g_sqrt
        v3a_sqrt_cell #(
            .SW (SW),
            .K  (RB - 1 - g),
            .DW (BW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_valid (w_sv[g]),
            .i_x     (w_sx[g]),
            .i_res   (w_sr[g]),
            .i_data  (w_sb[g]),
            .o_valid (w_sv[g+1]),
            .o_x     (w_sx[g+1]),
            .o_res   (w_sr[g+1]),
            .o_data  (w_sb[g+1])
        );
    end

    // ---------------- stage 3: round root, length result, numerators ----------------
    t_bundle       s_b3_in;
    logic [LW-1:0] n_len;
    logic [RB:0]   s_len_s;
    logic [RB-1:0] s_mag [3];
    logic [NW-1:0] n_num [3];
    t_bundle       n_b3;
    t_bundle       r_b3;
    logic [LW-1:0] r_len3;
    logic [NW-1:0] r_num3 [3];
    logic          r_v3;

    assign s_b3_in = w_sb[RB];

    always_comb begin
        // round to nearest: bump when remainder exceeds the root
        n_len   = w_sr[RB][LW-1:0] + LW'(w_sx[RB] > w_sr[RB]);
        s_len_s = sat_w($signed({{(SUMW-LW){1'b0}}, n_len}));
        s_mag[0] = s_b3_in.rx[RB-1] ? (~s_b3_in.rx + 1'b1) : s_b3_in.rx;
        s_mag[1] = s_b3_in.ry[RB-1] ? (~s_b3_in.ry + 1'b1) : s_b3_in.ry;
        s_mag[2] = s_b3_in.rz[RB-1] ? (~s_b3_in.rz + 1'b1) : s_b3_in.rz;
        for (int i = 0; i < 3; i++) begin
            n_num[i] = (NW'(s_mag[i]) << FRAC_BITS) + NW'(n_len >> 1);
        end
        n_b3 = s_b3_in;
        if (s_b3_in.op == OP_LENGTH) begin
            n_b3.rx = '0;
            n_b3.ry = '0;
            n_b3.rz = '0;
            n_b3.sc = $signed(s_len_s[RB-1:0]);
            n_b3.ov = s_len_s[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (s_en) begin
            r_v3 <= w_sv[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_b3   <= n_b3;
            r_len3 <= n_len;
            r_num3 <= n_num;
        end
    end

    // ---------------- divider chain ----------------
    logic          w_dv [QW+1];
    logic [NW-1:0] w_drem [QW+1][3];
    logic [QW-1:0] w_dq [QW+1][3];
    logic [LW-1:0] w_dd [QW+1];
    logic [BW-1:0] w_db [QW+1];

    assign w_dv[0]   = r_v3;
    assign w_drem[0] = r_num3;
    assign w_dd[0]   = r_len3;
    assign w_db[0]   = r_b3;
    for (genvar l = 0; l < 3; l++) begin : g_q0
        assign w_dq[0][l] = '0;
    end

    for (genvar g = 0; g < QW; g++) begin : g_div
        v3a_div_cell #(
            .NW (NW),
            .LW (LW),
            .QW (QW),
            .J  (QW - 1 - g),
            .DW (BW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_valid (w_dv[g]),
            .i_rem   (w_drem[g]),
            .i_q     (w_dq[g]),
            .i_div   (w_dd[g]),
            .i_data  (w_db[g]),
            .o_valid (w_dv[g+1]),
            .o_rem   (w_drem[g+1]),
            .o_q     (w_dq[g+1]),
            .o_div   (w_dd[g+1]),
            .o_data  (w_db[g+1])
        );
    end

    // ---------------- final: sign and saturate quotients, output register ----------------
    t_bundle                s_bf;
    t_bundle                s_res;
    logic signed [SUMW-1:0] s_qs [3];
    logic [RB:0]            s_qsat [3];
    logic [2:0]             s_neg;
    t_out_item              n_out;
    t_out_item              r_out_item;
    logic                   r_out_valid;

    assign s_bf = w_db[QW];

    always_comb begin
        s_neg = {s_bf.rz[RB-1], s_bf.ry[RB-1], s_bf.rx[RB-1]};
        for (int i = 0; i < 3; i++) begin
            s_qs[i] = $signed({{(SUMW-QW){1'b0}}, w_dq[QW][i]});
            if (s_neg[i]) begin
                s_qs[i] = -s_qs[i];
            end
            s_qsat[i] = sat_w(s_qs[i]);
        end
        s_res = s_bf;
        if (s_bf.op == OP_NORM) begin
            if (w_dd[QW] == '0) begin
                // zero vector comes back unchanged
                s_res.rx = '0;
                s_res.ry = '0;
                s_res.rz = '0;
                s_res.ov = 1'b0;
            end else begin
                s_res.rx = $signed(s_qsat[0][RB-1:0]);
                s_res.ry = $signed(s_qsat[1][RB-1:0]);
                s_res.rz = $signed(s_qsat[2][RB-1:0]);
                s_res.ov = s_qsat[0][RB] | s_qsat[1][RB] | s_qsat[2][RB];
            end
            s_res.sc = '0;
        end
        n_out.rx         = 32'(s_res.rx);
        n_out.ry         = 32'(s_res.ry);
        n_out.rz         = 32'(s_res.rz);
        n_out.scalar_out = 32'(s_res.sc);
        n_out.overflow   = s_res.ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_en) begin
            r_out_valid <= w_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_out_item <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ---------------- assertions ----------------
    t_bundle s_bd_end;
    assign s_bd_end = w_db[QW];

    // root remainder never exceeds twice the root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sv[RB] && (s_b3_in.op == OP_LENGTH || s_b3_in.op == OP_NORM)
        |-> ({1'b0, w_sx[RB]} <= {w_sr[RB], 1'b0}))
        else $error("square root remainder out of range");

    // divider remainder ends below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv[QW] && s_bd_end.op == OP_NORM && w_dd[QW] != '0
        |-> (w_drem[QW][0] < NW'(w_dd[QW]) && w_drem[QW][1] < NW'(w_dd[QW])
             && w_drem[QW][2] < NW'(w_dd[QW])))
        else $error("divider remainder not below divisor");

    // overflow only with some field at a saturation limit
    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.overflow
        |-> (o_out_item.rx == OUT_HI || o_out_item.rx == OUT_LO
             || o_out_item.ry == OUT_HI || o_out_item.ry == OUT_LO
             || o_out_item.rz == OUT_HI || o_out_item.rz == OUT_LO
             || o_out_item.scalar_out == OUT_HI || o_out_item.scalar_out == OUT_LO))
        else $error("overflow without saturated field");

    // a result is either scalar or vector
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.scalar_out != '0
        |-> (o_out_item.rx == '0 && o_out_item.ry == '0 && o_out_item.rz == '0))
        else $error("scalar and vector result both nonzero");

endmodule

// File: test/vector3_alu_tb.sv
`timescale 1ns / 1ps
// Testbench for the vector ALU: random and directed items checked against a predictor.
module vector3_alu_tb;
    import v3a_pkg::*;

    localparam int FRAC = 16;
    localparam int LAT  = 32 + FRAC + 5;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        mismatches = 0;
    bit        stim_done = 1'b0;
    int        cycle = 0;
    int        rx_cycle = 0;

    vector3_alu u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // --- predictor ---
    function automatic logic signed [63:0] sat_word(input logic signed [63:0] v,
                                                    inout bit ov);
        if (v > 64'sd2147483647) begin
            ov = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ov = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // round half up of sum / 2^FRAC; arithmetic shift is floor
    function automatic logic signed [63:0] round_q(input logic signed [66:0] s);
        return 64'(((s + 67'sd32768) >>> FRAC));
    endfunction

    function automatic logic [63:0] root_nearest(input logic [63:0] n);
        logic [63:0] x, res, bit_w;
        x = n;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > x) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (x >= res + bit_w) begin
                x = x - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        if (n - res * res > res) res = res + 1;
        return res;
    endfunction

    function automatic logic signed [63:0] unit_comp(input logic signed [63:0] c,
                                                     input logic [63:0] len);
        logic [63:0] mag, q;
        mag = (c < 0) ? 64'(-c) : 64'(c);
        q = ((mag << FRAC) + (len >> 1)) / len;
        return (c < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_out_item vector_result(input t_in_item it);
        t_out_item r;
        bit ov;
        logic signed [63:0] ax, ay, az, bx, by, bz, px, py, pz;
        logic [63:0] sq, len;
        ax = it.ax; ay = it.ay; az = it.az;
        bx = it.bx; by = it.by; bz = it.bz;
        ov = 1'b0;
        r = '0;
        case (it.op)
            OP_DOT: begin
                r.scalar_out = 32'(sat_word(round_q(67'(ax * bx) + 67'(ay * by)
                    + 67'(az * bz)), ov));
            end
            OP_CROSS: begin
                px = sat_word(round_q(67'(ay * bz) - 67'(az * by)), ov);
                py = sat_word(round_q(67'(az * bx) - 67'(ax * bz)), ov);
                pz = sat_word(round_q(67'(ax * by) - 67'(ay * bx)), ov);
                r.rx = 32'(px); r.ry = 32'(py); r.rz = 32'(pz);
            end
            OP_LENGTH, OP_NORM: begin
                sq = 64'(ax * ax) + 64'(ay * ay) + 64'(az * az);
                len = root_nearest(sq);
                if (it.op == OP_LENGTH) begin
                    r.scalar_out = 32'(sat_word($signed(len), ov));
                end else if (len != 0) begin
                    r.rx = 32'(sat_word(unit_comp(ax, len), ov));
                    r.ry = 32'(sat_word(unit_comp(ay, len), ov));
                    r.rz = 32'(sat_word(unit_comp(az, len), ov));
                end
            end
            OP_NEG: begin
                r.rx = 32'(sat_word(-ax, ov));
                r.ry = 32'(sat_word(-ay, ov));
                r.rz = 32'(sat_word(-az, ov));
            end
            default: ;
        endcase
        r.overflow = ov;
        return r;
    endfunction

    // --- stimulus ---
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 131072)) - 32'd65536;
            1: return $urandom();
            2: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
            3: return 32'($signed($urandom()) >>> $urandom_range(8, 30));
            4: return 32'h0;
            default: return 32'($urandom_range(0, 1 << 20)) - 32'd524288;
        endcase
    endfunction

    task automatic add_item(input logic [2:0] op, input logic [31:0] ax, ay, az,
                            input logic [31:0] bx, by, bz);
        t_in_item it;
        it.op = op;
        it.ax = ax; it.ay = ay; it.az = az;
        it.bx = bx; it.by = by; it.bz = bz;
        pending_items.push_back(it);
    endtask

    initial begin
        logic [2:0] op;
        for (int k = 0; k < 8; k++) begin
            op = 3'(k);
            add_item(op, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                     32'h80000000, 32'h80000000, 32'h7fffffff);
        end
        add_item(OP_NORM, 0, 0, 0, 5, 6, 7);
        add_item(OP_NEG, 32'h80000000, 0, 32'hffffffff, 0, 0, 0);
        add_item(OP_DOT, 32'h00018000, 32'h00008000, 0, 32'h00000001, 32'h00000001, 0);
        add_item(OP_DOT, 32'hffffffff, 0, 0, 32'h00008000, 0, 0);
        add_item(OP_CROSS, 32'h00010000, 0, 0, 0, 32'h00010000, 0);
        add_item(OP_LENGTH, 32'h00030000, 32'h00040000, 0, 0, 0, 0);
        add_item(OP_LENGTH, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
        add_item(OP_NORM, 32'h00000001, 0, 0, 0, 0, 0);
        add_item(OP_NORM, 32'h80000000, 32'h7fffffff, 32'h00000001, 0, 0, 0);
        add_item(OP_NORM, 0, 32'hfffd0000, 32'h00040000, 0, 0, 0);
        add_item(OP_NEG, 32'h7fffffff, 32'h00000001, 0, 0, 0, 0);
        add_item(OP_DOT, 0, 0, 0, 0, 0, 0);
        for (int n = 0; n < 1350; n++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            add_item(op, rand_comp(), rand_comp(), rand_comp(),
                     rand_comp(), rand_comp(), rand_comp());
        end
        stim_done = 1'b1;
    end

    // --- driver ---
    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) expected_results.push_back(vector_result(in_item));
            if (pending_items.size() > 0
                    && ((cycle > 400 && cycle < 900) || $urandom_range(0, 99) >= 31)) begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // --- receiver and monitor ---
    always @(posedge clk) begin
        t_out_item exp_r;
        rx_cycle <= rx_cycle + 1;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result %p", out_item);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== out_item) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %p actual %p", exp_r, out_item);
                    end
                end
            end
            // long hold-off so the pipe fills and back-pressures the input
            if (rx_cycle > 1200 && rx_cycle < 1400) begin
                out_ready <= 1'b0;
            end else if (rx_cycle > 2000 && rx_cycle < 2600) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= 31);
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (LAT * 2) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/v3a_pkg.sv
hw/rtl/v3a_sqrt_cell.sv
hw/rtl/v3a_div_cell.sv
hw/rtl/vector3_alu.sv
test/vector3_alu_tb.sv
